// ----- rtl/assert_macros.svh -----
// assertion macros shared by the scanner rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CTS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CTS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define CTS_ASSERT(lbl, clk, rst, prop, msg)
`define CTS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/cts_pkg.sv -----
`timescale 1ns / 1ps
package cts_pkg;

   localparam int RESULT_DEPTH = 4;
   localparam int RESULT_PTR_W = 2;
   localparam int RESULT_CNT_W = 3;

   typedef enum logic [3:0] {
      M_IDLE, M_OP, M_DOT1, M_DOT2, M_ZERO, M_HEX0, M_HEX, M_DEC, M_NAME, M_HASH, M_DIR
   } scan_mode_type;

   localparam logic [2:0] E_NONE     = 3'd0;
   localparam logic [2:0] E_BAD_NUM  = 3'd1;
   localparam logic [2:0] E_BAD_NAME = 3'd2;
   localparam logic [2:0] E_BAD_TOK  = 3'd3;
   localparam logic [2:0] E_UNSUP    = 3'd4;

   localparam logic [5:0] K_NONE = 6'd0;
   localparam logic [5:0] K_LPAREN = 6'd0, K_LBRACK = 6'd1, K_LBRACE = 6'd2;
   localparam logic [5:0] K_RPAREN = 6'd3, K_RBRACK = 6'd4, K_RBRACE = 6'd5;
   localparam logic [5:0] K_COMMA = 6'd6, K_PERIOD = 6'd7, K_ELLIPSIS = 6'd8;
   localparam logic [5:0] K_COLON = 6'd9, K_SEMI = 6'd10;
   localparam logic [5:0] K_ADD = 6'd11, K_INC = 6'd12, K_ADD_ASSIGN = 6'd13;
   localparam logic [5:0] K_SUB = 6'd14, K_DEC = 6'd15, K_ARROW = 6'd16;
   localparam logic [5:0] K_SUB_ASSIGN = 6'd17, K_MUL = 6'd18, K_MUL_ASSIGN = 6'd19;
   localparam logic [5:0] K_QUO = 6'd20, K_QUO_ASSIGN = 6'd21;
   localparam logic [5:0] K_REM = 6'd22, K_REM_ASSIGN = 6'd23;
   localparam logic [5:0] K_AND = 6'd24, K_LAND = 6'd25, K_AND_NOT = 6'd26;
   localparam logic [5:0] K_AND_NOT_ASSIGN = 6'd27, K_AND_ASSIGN = 6'd28;
   localparam logic [5:0] K_OR = 6'd29, K_LOR = 6'd30, K_OR_ASSIGN = 6'd31;
   localparam logic [5:0] K_XOR = 6'd32, K_XOR_ASSIGN = 6'd33;
   localparam logic [5:0] K_LSS = 6'd34, K_LEQ = 6'd35, K_SHL = 6'd36;
   localparam logic [5:0] K_SHL_ASSIGN = 6'd37;
   localparam logic [5:0] K_GTR = 6'd38, K_GEQ = 6'd39, K_SHR = 6'd40;
   localparam logic [5:0] K_SHR_ASSIGN = 6'd41;
   localparam logic [5:0] K_ASSIGN = 6'd42, K_EQL = 6'd43, K_NOT = 6'd44, K_NEQ = 6'd45;
   localparam logic [5:0] K_INT = 6'd46, K_IDENT = 6'd47, K_DIRECT = 6'd48, K_END = 6'd49;

   typedef struct packed {
      logic [5:0]  kind;
      logic [63:0] value;
      logic [15:0] line;
      logic [15:0] column;
      logic [2:0]  err;
      logic        last;
   } result_type;

endpackage

// ----- rtl/cts_result_fifo.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cts_result_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_n,
   input  cts_pkg::result_type  push_a,
   input  cts_pkg::result_type  push_b,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cts_pkg::result_type  rsp_item
);

   cts_pkg::result_type mem_ff [cts_pkg::RESULT_DEPTH];
   logic [cts_pkg::RESULT_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [cts_pkg::RESULT_CNT_W-1:0] count_ff, count_in;
   logic pop;

   assign room      = count_ff <= cts_pkg::RESULT_CNT_W'(cts_pkg::RESULT_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_item  = mem_ff[rd_ff];
   assign pop       = rsp_valid & rsp_ready;

   always_comb begin
      wr_in    = wr_ff + cts_pkg::RESULT_PTR_W'(push_n);
      rd_in    = rd_ff + cts_pkg::RESULT_PTR_W'(pop);
      count_in = count_ff + cts_pkg::RESULT_CNT_W'(push_n) - cts_pkg::RESULT_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ff] <= push_a;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ff + cts_pkg::RESULT_PTR_W'(1)] <= push_b;
      end
   end

   `CTS_ASSERT(a_count_bound, clock, reset, count_ff <= cts_pkg::RESULT_CNT_W'(cts_pkg::RESULT_DEPTH), "result queue overflow")
   `CTS_ASSERT(a_pop_only, clock, reset, (pop && push_n == 2'd0) |=> (count_ff == $past(count_ff) - 1'b1), "pop count slip")
   `CTS_ASSERT(a_push_two, clock, reset, (!pop && push_n == 2'd2) |=> (count_ff == $past(count_ff) + 2'd2), "double push count slip")

endmodule

// ----- rtl/c_token_scanner_top.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// channel  ports                      dir  payload
// req      req_tvalid/tready/tdata    in   source byte, tlast = end of input
// rsp      rsp_tvalid/tready/tdata    out  token or error, tlast = last for that byte
//
// one byte per cycle while the queue has room: input register, one pass of scan logic, 4-entry result queue
// each byte yields zero to two items; a byte is taken while the queue has room for two
// reset clears scan state, positions to line 1 column 1, and the queue
// a stalled rsp side backs up into req_tready once the queue holds three items
// after an error or the end token every byte is consumed silently until reset
module c_token_scanner_top #(
   parameter int MAX_NAME_LEN  = 64,
   parameter int POSITION_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // char_byte
   input  logic         req_tlast,   // is_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // token_kind, token_value, token_line, token_column, error_code
   output logic         rsp_tlast    // is_last
);

   localparam int NLEN_W = $clog2(MAX_NAME_LEN + 1);
   localparam int POS_W  = POSITION_BITS;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   logic        in_valid_ff, in_end_ff;
   logic [7:0]  in_byte_ff;
   logic        fire, fifo_room;

   cts_pkg::scan_mode_type mode_ff, mode_in;
   logic [5:0]        pend_ff, pend_in;
   logic [63:0]       acc_ff, acc_in;
   logic [NLEN_W-1:0] nlen_ff, nlen_in;
   logic [POS_W-1:0]  sline_ff, sline_in, scol_ff, scol_in;
   logic [POS_W-1:0]  cline_ff, cline_in, ccol_ff, ccol_in;
   logic              halted_ff, halted_in;

   logic [7:0] c;
   logic is_ws, is_dig, is_letter, is_name, num_end, name_end, hex_ok;
   logic [3:0] hex_d;
   logic [6:0] ext, single, opst;

   logic        a_v, go_idle, a_fail;
   logic [5:0]  a_kind;
   logic [63:0] a_val;
   logic [2:0]  a_err;
   cts_pkg::scan_mode_type s_mode, i_mode;
   logic [5:0]        s_pend, i_pend;
   logic [63:0]       s_acc, i_acc;
   logic [NLEN_W-1:0] s_nlen, i_nlen;
   logic        b_v, b_go;
   logic [5:0]  b_kind;
   logic [2:0]  b_err;

   logic [1:0] push_n;
   cts_pkg::result_type ra, rb, push_a, push_b, out_item;

   function automatic logic [15:0] pos_out(input logic [POS_W-1:0] v);
      logic [32:0] w;
      w = 33'(v);
      return (w > 33'd65535) ? 16'hFFFF : w[15:0];
   endfunction

   function automatic logic [6:0] single_kind(input logic [7:0] ch);
      case (ch)
         "(":     return {1'b1, cts_pkg::K_LPAREN};
         "[":     return {1'b1, cts_pkg::K_LBRACK};
         "{":     return {1'b1, cts_pkg::K_LBRACE};
         ")":     return {1'b1, cts_pkg::K_RPAREN};
         "]":     return {1'b1, cts_pkg::K_RBRACK};
         "}":     return {1'b1, cts_pkg::K_RBRACE};
         ",":     return {1'b1, cts_pkg::K_COMMA};
         ":":     return {1'b1, cts_pkg::K_COLON};
         ";":     return {1'b1, cts_pkg::K_SEMI};
         default: return 7'd0;
      endcase
   endfunction

   function automatic logic [6:0] op_start(input logic [7:0] ch);
      case (ch)
         "+":     return {1'b1, cts_pkg::K_ADD};
         "-":     return {1'b1, cts_pkg::K_SUB};
         "*":     return {1'b1, cts_pkg::K_MUL};
         "/":     return {1'b1, cts_pkg::K_QUO};
         "%":     return {1'b1, cts_pkg::K_REM};
         "&":     return {1'b1, cts_pkg::K_AND};
         "|":     return {1'b1, cts_pkg::K_OR};
         "^":     return {1'b1, cts_pkg::K_XOR};
         "<":     return {1'b1, cts_pkg::K_LSS};
         ">":     return {1'b1, cts_pkg::K_GTR};
         "=":     return {1'b1, cts_pkg::K_ASSIGN};
         "!":     return {1'b1, cts_pkg::K_NOT};
         default: return 7'd0;
      endcase
   endfunction

   function automatic logic [6:0] op_extend(input logic [5:0] k, input logic [7:0] ch);
      logic [6:0] r;
      r = 7'd0;
      case (k)
         cts_pkg::K_ADD: begin
            if (ch == "+") r = {1'b1, cts_pkg::K_INC};
            else if (ch == "=") r = {1'b1, cts_pkg::K_ADD_ASSIGN};
         end
         cts_pkg::K_SUB: begin
            if (ch == "-") r = {1'b1, cts_pkg::K_DEC};
            else if (ch == ">") r = {1'b1, cts_pkg::K_ARROW};
            else if (ch == "=") r = {1'b1, cts_pkg::K_SUB_ASSIGN};
         end
         cts_pkg::K_MUL: if (ch == "=") r = {1'b1, cts_pkg::K_MUL_ASSIGN};
         cts_pkg::K_QUO: if (ch == "=") r = {1'b1, cts_pkg::K_QUO_ASSIGN};
         cts_pkg::K_REM: if (ch == "=") r = {1'b1, cts_pkg::K_REM_ASSIGN};
         cts_pkg::K_AND: begin
            if (ch == "&") r = {1'b1, cts_pkg::K_LAND};
            else if (ch == "^") r = {1'b1, cts_pkg::K_AND_NOT};
            else if (ch == "=") r = {1'b1, cts_pkg::K_AND_ASSIGN};
         end
         cts_pkg::K_AND_NOT: if (ch == "=") r = {1'b1, cts_pkg::K_AND_NOT_ASSIGN};
         cts_pkg::K_OR: begin
            if (ch == "|") r = {1'b1, cts_pkg::K_LOR};
            else if (ch == "=") r = {1'b1, cts_pkg::K_OR_ASSIGN};
         end
         cts_pkg::K_XOR: if (ch == "=") r = {1'b1, cts_pkg::K_XOR_ASSIGN};
         cts_pkg::K_LSS: begin
            if (ch == "=") r = {1'b1, cts_pkg::K_LEQ};
            else if (ch == "<") r = {1'b1, cts_pkg::K_SHL};
         end
         cts_pkg::K_SHL: if (ch == "=") r = {1'b1, cts_pkg::K_SHL_ASSIGN};
         cts_pkg::K_GTR: begin
            if (ch == "=") r = {1'b1, cts_pkg::K_GEQ};
            else if (ch == ">") r = {1'b1, cts_pkg::K_SHR};
         end
         cts_pkg::K_SHR: if (ch == "=") r = {1'b1, cts_pkg::K_SHR_ASSIGN};
         cts_pkg::K_ASSIGN: if (ch == "=") r = {1'b1, cts_pkg::K_EQL};
         cts_pkg::K_NOT: if (ch == "=") r = {1'b1, cts_pkg::K_NEQ};
         default: r = 7'd0;
      endcase
      return r;
   endfunction

   // input register
   assign fire       = in_valid_ff & fifo_room;
   assign req_tready = ~in_valid_ff | fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   // byte classes
   assign c = in_byte_ff;

   always_comb begin
      is_ws     = c inside {8'h20, 8'h0A, 8'h09, 8'h0B, 8'h0C, 8'h0D};
      is_dig    = c inside {[8'h30:8'h39]};
      is_letter = c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
      is_name   = is_letter | is_dig | (c == "_");
      num_end   = is_ws | (c inside {";", ")", "]", "}"});
      name_end  = is_ws | (c inside {";", "(", "[", "{"});
      hex_ok    = 1'b1;
      hex_d     = c[3:0];
      if (is_dig) begin
         hex_d = c[3:0];
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         hex_d = c[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
      ext    = op_extend(pend_ff, c);
      single = single_kind(c);
      opst   = op_start(c);
   end

   // pending token against this byte
   always_comb begin
      a_v     = 1'b0;
      a_kind  = cts_pkg::K_NONE;
      a_val   = '0;
      a_err   = cts_pkg::E_NONE;
      go_idle = 1'b0;
      s_mode  = mode_ff;
      s_pend  = pend_ff;
      s_acc   = acc_ff;
      s_nlen  = nlen_ff;
      if (in_end_ff) begin
         case (mode_ff)
            cts_pkg::M_OP: begin
               a_v = 1'b1; a_kind = pend_ff;
            end
            cts_pkg::M_DOT1: begin
               a_v = 1'b1; a_kind = cts_pkg::K_PERIOD;
            end
            cts_pkg::M_DOT2: begin
               a_v = 1'b1; a_err = cts_pkg::E_BAD_TOK;
            end
            cts_pkg::M_ZERO: begin
               a_v = 1'b1; a_err = cts_pkg::E_UNSUP;
            end
            cts_pkg::M_HEX0, cts_pkg::M_HEX, cts_pkg::M_DEC: begin
               a_v = 1'b1; a_err = cts_pkg::E_BAD_NUM;
            end
            cts_pkg::M_NAME: begin
               a_v = 1'b1; a_kind = cts_pkg::K_IDENT; a_val = 64'(nlen_ff);
            end
            cts_pkg::M_DIR: begin
               a_v = 1'b1; a_kind = cts_pkg::K_DIRECT; a_val = 64'(nlen_ff);
            end
            cts_pkg::M_HASH: begin
               a_v = 1'b1; a_err = cts_pkg::E_BAD_NAME;
            end
            default: ;
         endcase
      end else begin
         case (mode_ff)
            cts_pkg::M_OP: begin
               if (pend_ff == cts_pkg::K_QUO && (c == "/" || c == "*")) begin
                  a_v = 1'b1; a_err = cts_pkg::E_UNSUP;
               end else if (!ext[6]) begin
                  a_v = 1'b1; a_kind = pend_ff; go_idle = 1'b1;
               end else if (ext[5:0] inside {cts_pkg::K_AND_NOT, cts_pkg::K_SHL,
                                              cts_pkg::K_SHR}) begin
                  s_pend = ext[5:0];
               end else begin
                  a_v = 1'b1; a_kind = ext[5:0]; s_mode = cts_pkg::M_IDLE;
               end
            end
            cts_pkg::M_DOT1: begin
               if (c == ".") begin
                  s_mode = cts_pkg::M_DOT2;
               end else begin
                  a_v = 1'b1; a_kind = cts_pkg::K_PERIOD; go_idle = 1'b1;
               end
            end
            cts_pkg::M_DOT2: begin
               a_v = 1'b1;
               if (c == ".") begin
                  a_kind = cts_pkg::K_ELLIPSIS; s_mode = cts_pkg::M_IDLE;
               end else begin
                  a_err = cts_pkg::E_BAD_TOK;
               end
            end
            cts_pkg::M_ZERO: begin
               if (num_end) begin
                  a_v = 1'b1; a_kind = cts_pkg::K_INT; go_idle = 1'b1;
               end else if (c == "x" || c == "X") begin
                  s_mode = cts_pkg::M_HEX0;
               end else begin
                  a_v = 1'b1; a_err = cts_pkg::E_UNSUP;
               end
            end
            cts_pkg::M_HEX0: begin
               if (hex_ok) begin
                  s_acc = {60'd0, hex_d}; s_mode = cts_pkg::M_HEX;
               end else begin
                  a_v = 1'b1; a_err = cts_pkg::E_BAD_NUM;
               end
            end
            cts_pkg::M_HEX: begin
               if (hex_ok) begin
                  s_acc = {acc_ff[59:0], hex_d};
               end else if (num_end) begin
                  a_v = 1'b1; a_kind = cts_pkg::K_INT; a_val = acc_ff; go_idle = 1'b1;
               end else begin
                  a_v = 1'b1; a_err = cts_pkg::E_BAD_NUM;
               end
            end
            cts_pkg::M_DEC: begin
               if (is_dig) begin
                  s_acc = {acc_ff[60:0], 3'd0} + {acc_ff[62:0], 1'b0} + {60'd0, c[3:0]};
               end else if (num_end) begin
                  a_v = 1'b1; a_kind = cts_pkg::K_INT; a_val = acc_ff; go_idle = 1'b1;
               end else begin
                  a_v = 1'b1; a_err = cts_pkg::E_BAD_NUM;
               end
            end
            cts_pkg::M_NAME, cts_pkg::M_DIR: begin
               if (is_name) begin
                  if (nlen_ff >= NLEN_W'(MAX_NAME_LEN)) begin
                     a_v = 1'b1; a_err = cts_pkg::E_BAD_NAME;
                  end else begin
                     s_nlen = nlen_ff + NLEN_W'(1);
                  end
               end else if (name_end) begin
                  a_v     = 1'b1;
                  a_kind  = (mode_ff == cts_pkg::M_NAME) ? cts_pkg::K_IDENT : cts_pkg::K_DIRECT;
                  a_val   = 64'(nlen_ff);
                  go_idle = 1'b1;
               end else begin
                  a_v = 1'b1; a_err = cts_pkg::E_BAD_NAME;
               end
            end
            cts_pkg::M_HASH: begin
               if (is_letter || c == "_") begin
                  s_nlen = NLEN_W'(1); s_mode = cts_pkg::M_DIR;
               end else begin
                  a_v = 1'b1; a_err = cts_pkg::E_BAD_NAME;
               end
            end
            default: go_idle = 1'b1;
         endcase
      end
      a_fail = a_err != cts_pkg::E_NONE;
   end

   // byte seen between tokens
   always_comb begin
      b_v    = 1'b0;
      b_kind = cts_pkg::K_NONE;
      b_err  = cts_pkg::E_NONE;
      i_mode = cts_pkg::M_IDLE;
      i_pend = pend_ff;
      i_acc  = acc_ff;
      i_nlen = nlen_ff;
      if (is_ws) begin
         i_mode = cts_pkg::M_IDLE;
      end else if (c == ".") begin
         i_mode = cts_pkg::M_DOT1;
      end else if (single[6]) begin
         b_v = 1'b1; b_kind = single[5:0];
      end else if (opst[6]) begin
         i_pend = opst[5:0]; i_mode = cts_pkg::M_OP;
      end else if (c == "#") begin
         i_mode = cts_pkg::M_HASH;
      end else if (c == 8'h22 || c == 8'h27) begin
         b_v = 1'b1; b_err = cts_pkg::E_UNSUP;
      end else if (c == "0") begin
         i_mode = cts_pkg::M_ZERO;
      end else if (is_dig) begin
         i_acc = {60'd0, c[3:0]}; i_mode = cts_pkg::M_DEC;
      end else if (is_letter || c == "_") begin
         i_nlen = NLEN_W'(1); i_mode = cts_pkg::M_NAME;
      end else begin
         b_v = 1'b1; b_err = cts_pkg::E_BAD_NAME;
      end
   end

   // next state
   always_comb begin
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      acc_in    = acc_ff;
      nlen_in   = nlen_ff;
      sline_in  = sline_ff;
      scol_in   = scol_ff;
      cline_in  = cline_ff;
      ccol_in   = ccol_ff;
      halted_in = halted_ff;
      if (fire && !halted_ff) begin
         if (in_end_ff) begin
            halted_in = 1'b1;
            mode_in   = cts_pkg::M_IDLE;
         end else begin
            if (a_fail) begin
               halted_in = 1'b1;
               mode_in   = cts_pkg::M_IDLE;
            end else if (go_idle) begin
               mode_in  = i_mode;
               pend_in  = i_pend;
               acc_in   = i_acc;
               nlen_in  = i_nlen;
               sline_in = cline_ff;
               scol_in  = ccol_ff;
               if (b_v && b_err != cts_pkg::E_NONE) begin
                  halted_in = 1'b1;
                  mode_in   = cts_pkg::M_IDLE;
               end
            end else begin
               mode_in = s_mode;
               pend_in = s_pend;
               acc_in  = s_acc;
               nlen_in = s_nlen;
            end
            if (c == 8'h0A) begin
               if (cline_ff != POS_MAX) cline_in = cline_ff + POS_W'(1);
               ccol_in = POS_W'(1);
            end else if (ccol_ff != POS_MAX) begin
               ccol_in = ccol_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= cts_pkg::M_IDLE;
         pend_ff   <= '0;
         acc_ff    <= '0;
         nlen_ff   <= '0;
         sline_ff  <= POS_W'(1);
         scol_ff   <= POS_W'(1);
         cline_ff  <= POS_W'(1);
         ccol_ff   <= POS_W'(1);
         halted_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         acc_ff    <= acc_in;
         nlen_ff   <= nlen_in;
         sline_ff  <= sline_in;
         scol_ff   <= scol_in;
         cline_ff  <= cline_in;
         ccol_ff   <= ccol_in;
         halted_ff <= halted_in;
      end
   end

   // result items
   always_comb begin
      ra.kind   = a_kind;
      ra.value  = a_val;
      ra.line   = pos_out(sline_ff);
      ra.column = pos_out(scol_ff);
      ra.err    = a_err;
      ra.last   = 1'b0;
      rb.value  = '0;
      rb.line   = pos_out(cline_ff);
      rb.column = pos_out(ccol_ff);
      rb.last   = 1'b0;
      if (in_end_ff) begin
         rb.kind = cts_pkg::K_END;
         rb.err  = cts_pkg::E_NONE;
         b_go    = ~a_fail;
      end else begin
         rb.kind = b_kind;
         rb.err  = b_err;
         b_go    = go_idle & b_v;
      end
      push_n = 2'd0;
      if (fire && !halted_ff) begin
         push_n = 2'(a_v) + 2'(b_go);
      end
      push_a = a_v ? ra : rb;
      push_b = rb;
      push_a.last = (push_n == 2'd1);
      push_b.last = 1'b1;
   end

   cts_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_a    (push_a),
      .push_b    (push_b),
      .room      (fifo_room),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (out_item)
   );

   assign rsp_tdata = {7'd0, out_item.err, out_item.column, out_item.line,
                       out_item.value, out_item.kind};
   assign rsp_tlast = out_item.last;

   `CTS_ASSERT_IMPL(a_halt_silent, clock, reset, fire && halted_ff, push_n == 2'd0, "item after halt produced a result")
   `CTS_ASSERT(a_end_halts, clock, reset, (fire && !halted_ff && in_end_ff) |=> halted_ff, "end mark did not halt")
   `CTS_ASSERT_IMPL(a_push_room, clock, reset, push_n != 2'd0, fifo_room, "push without queue room")
   `CTS_ASSERT_IMPL(a_end_gives, clock, reset, fire && !halted_ff && in_end_ff, push_n != 2'd0, "end mark gave no result")

endmodule
